/* hw/rtl/bir_pkg.sv */
// ----------------------------------------------------------------------------
// bir_pkg: shared constants and types for the bilinear resizer
// Fixed-point widths, register indexes and inter-stage structs.
// ----------------------------------------------------------------------------
package bir_pkg;

    localparam int MaxSrcRowsDef = 128;
    localparam int MaxSrcColsDef = 256;
    localparam int ChannelsDef   = 3;

    localparam int FracBits = 12;
    localparam int OneQ     = 1 << FracBits;
    localparam int HalfQ    = 1 << (FracBits - 1);

    // configuration register indexes
    localparam logic [1:0] RegSrcRows   = 2'd0;
    localparam logic [1:0] RegSrcCols   = 2'd1;
    localparam logic [1:0] RegScaleRows = 2'd2;
    localparam logic [1:0] RegScaleCols = 2'd3;

    localparam logic CmdWrite = 1'b0;
    localparam logic CmdRead  = 1'b1;

    // result of one coordinate mapping
    typedef struct packed {
        logic [8:0]  i0;
        logic [8:0]  i1;
        logic [11:0] w;
    } t_coord;

endpackage

/* hw/rtl/bir_ram.sv */
// ----------------------------------------------------------------------------
// bir_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bir_coord_map.sv */
// ----------------------------------------------------------------------------
// bir_coord_map: half-pixel coordinate mapping, two register stages
// Stage one forms (2d+1)*scale, stage two halves, offsets and clamps.
// ----------------------------------------------------------------------------
module bir_coord_map
    import bir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [8:0]  i_d,
    input  logic [15:0] i_scale,
    input  logic [9:0]  i_size,
    output t_coord      o_coord
);

    logic [25:0] r_prod;
    logic [9:0]  r_size;
    t_coord      r_coord;
    t_coord      n_coord;

    logic signed [27:0] s_p;
    logic signed [27:0] s_hi;
    logic signed [27:0] s_pc;
    logic [9:0]         s_inc;

    // product of the odd coordinate and the scale
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 26'({i_d, 1'b1}) * 26'(i_scale);
            r_size <= i_size;
        end
    end

    // halve, offset by half a pixel and clamp
    always_comb begin
        s_p  = $signed({3'b000, r_prod[25:1]}) - 28'sd2048;
        s_hi = $signed({6'b000000, 10'(r_size - 10'd1), 12'd0});
        if (s_p < 0) begin
            s_pc = '0;
        end else if (s_p > s_hi) begin
            s_pc = s_hi;
        end else begin
            s_pc = s_p;
        end
        n_coord.i0 = s_pc[20:12];
        n_coord.w  = s_pc[11:0];
        s_inc      = {1'b0, s_pc[20:12]} + 10'd1;
        n_coord.i1 = (s_inc < r_size) ? s_inc[8:0] : 9'(r_size - 10'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

/* hw/rtl/bir_blend.sv */
// ----------------------------------------------------------------------------
// bir_blend: four-neighbour weighted sum, two register stages
// Stage one blends along columns, stage two along rows.
// ----------------------------------------------------------------------------
module bir_blend
    import bir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_p00,
    input  logic [7:0]  i_p01,
    input  logic [7:0]  i_p10,
    input  logic [7:0]  i_p11,
    input  logic [11:0] i_u,
    input  logic [11:0] i_v,
    input  logic        i_zero,
    output logic [7:0]  o_pix
);

    logic [20:0] r_top;
    logic [20:0] r_bot;
    logic [11:0] r_u;
    logic        r_zero;
    logic [7:0]  r_pix;
    logic [12:0] s_vi;
    logic [12:0] s_ui;
    logic [33:0] s_sum;

    assign s_vi = 13'(OneQ) - {1'b0, i_v};
    assign s_ui = 13'(OneQ) - {1'b0, r_u};

    // column blend of both rows
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top  <= 21'(i_p00) * 21'(s_vi) + 21'(i_p01) * 21'(i_v);
            r_bot  <= 21'(i_p10) * 21'(s_vi) + 21'(i_p11) * 21'(i_v);
            r_u    <= i_u;
            r_zero <= i_zero;
        end
    end

    // row blend and truncation
    assign s_sum = 34'(r_top) * 34'(s_ui) + 34'(r_bot) * 34'(r_u);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= r_zero ? 8'd0 : s_sum[31:24];
        end
    end

    assign o_pix = r_pix;

endmodule

/* hw/rtl/bilinear_image_resize.sv */
// ----------------------------------------------------------------------------
// bilinear_image_resize: bilinear resizer with half-pixel centring
// Source image store plus a pipelined read path giving one pixel per read word.
// ----------------------------------------------------------------------------
// One word enters per cycle while the output register is free or being taken.
// A read word's pixel passes through six register stages, the first loaded at
// its acceptance edge: two of coordinate mapping, one banked memory read, two
// blend stages, one output register; the whole pipeline advances only when the
// output register is free or being taken. The source image lives in four
// memories banked by row and column parity so the four neighbours are read
// together; write words go to the single bank they select, two stages after
// acceptance so they reach the memory in step with the reads. No clearing pass.
// ----------------------------------------------------------------------------
module bilinear_image_resize
    import bir_pkg::*;
#(
    parameter int MAX_SRC_ROWS = MaxSrcRowsDef,
    parameter int MAX_SRC_COLS = MaxSrcColsDef,
    parameter int CHANNELS     = ChannelsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [1:0]  i_channel,
    input  logic [8:0]  i_row,
    input  logic [8:0]  i_col,
    input  logic [7:0]  i_pixel_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pixel_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int RH    = (MAX_SRC_ROWS + 1) / 2;
    localparam int CH    = (MAX_SRC_COLS + 1) / 2;
    localparam int RHB   = (RH > 1) ? $clog2(RH) : 1;
    localparam int CHB   = (CH > 1) ? $clog2(CH) : 1;
    localparam int CHNB  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * RH * CH;
    localparam int AB    = $clog2(DEPTH);

    // configuration registers
    logic [7:0]  r_src_rows;
    logic [8:0]  r_src_cols;
    logic [15:0] r_scale_rows;
    logic [15:0] r_scale_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_rows   <= 8'd80;
            r_src_cols   <= 9'd160;
            r_scale_rows <= 16'd2048;
            r_scale_cols <= 16'd2048;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegSrcRows:   r_src_rows   <= i_cfg_data[7:0];
                RegSrcCols:   r_src_cols   <= i_cfg_data[8:0];
                RegScaleRows: r_scale_rows <= i_cfg_data;
                RegScaleCols: r_scale_cols <= i_cfg_data;
                default:      ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // effective sizes
    logic [9:0] s_rows;
    logic [9:0] s_cols;
    always_comb begin
        if (r_src_rows == 8'd0) begin
            s_rows = 10'd1;
        end else if ({2'b00, r_src_rows} > 10'(MAX_SRC_ROWS)) begin
            s_rows = 10'(MAX_SRC_ROWS);
        end else begin
            s_rows = {2'b00, r_src_rows};
        end
        if (r_src_cols == 9'd0) begin
            s_cols = 10'd1;
        end else if ({1'b0, r_src_cols} > 10'(MAX_SRC_COLS)) begin
            s_cols = 10'(MAX_SRC_COLS);
        end else begin
            s_cols = {1'b0, r_src_cols};
        end
    end

    // pipeline advance
    logic s_adv;
    assign s_adv   = !o_valid || i_ready;
    assign o_ready = s_adv;

    logic s_acc;
    assign s_acc = i_valid && s_adv;

    // image writes
    logic          s_we;
    logic [3:0]    s_bank_we;
    logic [AB-1:0] s_waddr;
    assign s_we = s_acc && (i_command == CmdWrite)
               && ({30'd0, i_channel} < CHANNELS)
               && ({1'b0, i_row} < s_rows) && ({1'b0, i_col} < s_cols);
    assign s_waddr = AB'((i_channel * RH + (i_row >> 1)) * CH + (i_col >> 1));
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            s_bank_we[b] = s_we && (b[1] == i_row[0]) && (b[0] == i_col[0]);
        end
    end

    // write words travel to the memory stage beside the reads
    logic [3:0]    r_bank_we1, r_bank_we2;
    logic [AB-1:0] r_waddr1, r_waddr2;
    logic [7:0]    r_wdata1, r_wdata2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_we1 <= '0;
            r_bank_we2 <= '0;
        end else if (s_adv) begin
            r_bank_we1 <= s_bank_we;
            r_bank_we2 <= r_bank_we1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_waddr1 <= s_waddr;
            r_waddr2 <= r_waddr1;
            r_wdata1 <= i_pixel_in;
            r_wdata2 <= r_wdata1;
        end
    end

    // read request pipeline, valid bits and channel
    logic [1:0] r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [1:0] r_ch1, r_ch2;
    logic       r_out_v;

    logic s_rd;
    assign s_rd = s_acc && (i_command == CmdRead);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= '0; r_v2 <= '0; r_v3 <= '0; r_v4 <= '0; r_v5 <= '0;
            r_out_v <= 1'b0;
        end else if (s_adv) begin
            // bit0 valid, bit1 forced zero result
            r_v1 <= {s_rd && ({30'd0, i_channel} >= CHANNELS), s_rd};
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_out_v <= r_v5[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_ch1 <= i_channel;
            r_ch2 <= r_ch1;
        end
    end

    // coordinate mapping
    t_coord s_rc, s_cc;
    bir_coord_map u_map_row (
        .i_clk(i_clk), .i_en(s_adv), .i_d(i_row), .i_scale(r_scale_rows),
        .i_size(s_rows), .o_coord(s_rc)
    );
    bir_coord_map u_map_col (
        .i_clk(i_clk), .i_en(s_adv), .i_d(i_col), .i_scale(r_scale_cols),
        .i_size(s_cols), .o_coord(s_cc)
    );

    // banked neighbour addressing: bank selected by row and column parity
    logic [8:0]    s_re_r, s_ro_r, s_ce_c, s_co_c;
    logic [AB-1:0] s_raddr [4];
    logic [7:0]    s_rdata [4];
    logic [CHNB-1:0] s_chn;
    assign s_chn  = CHNB'(r_ch2);
    assign s_re_r = s_rc.i0[0] ? s_rc.i1 : s_rc.i0;
    assign s_ro_r = s_rc.i0[0] ? s_rc.i0 : s_rc.i1;
    assign s_ce_c = s_cc.i0[0] ? s_cc.i1 : s_cc.i0;
    assign s_co_c = s_cc.i0[0] ? s_cc.i0 : s_cc.i1;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic [8:0] rr;
            logic [8:0] cc;
            rr = b[1] ? s_ro_r : s_re_r;
            cc = b[0] ? s_co_c : s_ce_c;
            s_raddr[b] = AB'((s_chn * RH + RHB'(rr >> 1)) * CH + CHB'(cc >> 1));
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        bir_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
            .i_clk(i_clk), .i_we(r_bank_we2[b] && s_adv), .i_waddr(r_waddr2),
            .i_wdata(r_wdata2), .i_re(s_adv), .i_raddr(s_raddr[b]),
            .o_rdata(s_rdata[b])
        );
    end

    // carry weights and parities alongside the memory read
    logic [11:0] r_u3, r_v3w;
    logic        r_rpar, r_cpar;
    logic        r_rsame, r_csame;
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_u3    <= s_rc.w;
            r_v3w   <= s_cc.w;
            r_rpar  <= s_rc.i0[0];
            r_cpar  <= s_cc.i0[0];
            r_rsame <= (s_rc.i0 == s_rc.i1);
            r_csame <= (s_cc.i0 == s_cc.i1);
        end
    end

    // pick neighbours out of the banks
    logic [1:0] s_b00, s_b01, s_b10, s_b11;
    assign s_b00 = {r_rpar, r_cpar};
    assign s_b01 = {r_rpar, r_cpar ^ !r_csame};
    assign s_b10 = {r_rpar ^ !r_rsame, r_cpar};
    assign s_b11 = {r_rpar ^ !r_rsame, r_cpar ^ !r_csame};

    logic [7:0] s_pix;
    bir_blend u_blend (
        .i_clk(i_clk), .i_en(s_adv),
        .i_p00(s_rdata[s_b00]), .i_p01(s_rdata[s_b01]),
        .i_p10(s_rdata[s_b10]), .i_p11(s_rdata[s_b11]),
        .i_u(r_u3), .i_v(r_v3w), .i_zero(r_v3[1]), .o_pix(s_pix)
    );

    // output register
    logic [7:0] r_out_pix;
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out_pix <= s_pix;
        end
    end
    assign o_valid     = r_out_v;
    assign o_pixel_out = r_out_pix;

    // checks
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && r_v5[0] |=> o_valid)
        else $error("result lost at output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_adv |=> $stable(r_v5) && $stable(r_v1))
        else $error("pipeline moved during stall");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1[1] |-> r_v1[0])
        else $error("zero flag without request");

endmodule

/* dv/tb_bilinear_image_resize.sv */
// ----------------------------------------------------------------------------
// tb_bilinear_image_resize: self-checking bench for the bilinear resizer
// Drives pixel writes and resize requests through random idling on both sides,
// predicts each interpolated pixel from a local copy of the source image and
// registers or takes a fixed value, and compares the returned words in order.
// ----------------------------------------------------------------------------
module tb_bilinear_image_resize;
    import bir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxRows  = MaxSrcRowsDef;
    localparam int MaxCols  = MaxSrcColsDef;
    localparam int NumChan  = ChannelsDef;
    localparam int Latency  = 12;
    localparam int StallMax = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = CmdWrite;
    logic [1:0]  i_channel = '0;
    logic [8:0]  i_row = '0;
    logic [8:0]  i_col = '0;
    logic [7:0]  i_pixel_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_pixel_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = RegSrcRows;
    logic [15:0] i_cfg_data = '0;

    bilinear_image_resize dut (.*);

    always #1 i_clk = ~i_clk;

    // local copy of the block state
    logic [7:0]  image_copy [NumChan][MaxRows][MaxCols];
    bit          written    [NumChan][MaxRows][MaxCols];
    logic [7:0]  rows_reg = 8'd80;
    logic [8:0]  cols_reg = 9'd160;
    logic [15:0] scale_r_reg = 16'd2048;
    logic [15:0] scale_c_reg = 16'd2048;

    logic [7:0]  pixels_due [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          quiet_sink = 1'b0;
    bit          quiet_source = 1'b0;

    typedef struct {
        logic       cmd;
        logic [1:0] chan;
        int         row;
        int         col;
        logic [7:0] pix;
        bit         has_fixed;
        logic [7:0] fixed;
    } t_stim;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    function automatic int rows_in_use();
        if (rows_reg == 0) return 1;
        if (rows_reg > MaxRows) return MaxRows;
        return rows_reg;
    endfunction

    function automatic int cols_in_use();
        if (cols_reg == 0) return 1;
        if (cols_reg > MaxCols) return MaxCols;
        return cols_reg;
    endfunction

    // half-pixel mapping into source index and 12-bit weight
    function automatic void map_axis(input int d, input int scale, input int size,
                                     output int i0, output int i1, output int w);
        longint p;
        p = ((2 * longint'(d) + 1) * scale) / 2 - HalfQ;
        if (p < 0) p = 0;
        if (p > longint'(size - 1) * OneQ) p = longint'(size - 1) * OneQ;
        i0 = int'(p / OneQ);
        w  = int'(p % OneQ);
        i1 = (i0 + 1 < size) ? i0 + 1 : size - 1;
    endfunction

    function automatic logic [7:0] blend_pixel(input int ch, input int dr, input int dc);
        int r0, r1, u, c0, c1, v;
        longint acc;
        if (ch >= NumChan) return 8'd0;
        map_axis(dr, scale_r_reg, rows_in_use(), r0, r1, u);
        map_axis(dc, scale_c_reg, cols_in_use(), c0, c1, v);
        acc = longint'(image_copy[ch][r0][c0]) * (OneQ - u) * (OneQ - v)
            + longint'(image_copy[ch][r0][c1]) * (OneQ - u) * v
            + longint'(image_copy[ch][r1][c0]) * u * (OneQ - v)
            + longint'(image_copy[ch][r1][c1]) * u * v;
        return acc[31:24];
    endfunction

    // true when every neighbour a request would touch has been written
    function automatic bit neighbours_known(input int ch, input int dr, input int dc);
        int r0, r1, u, c0, c1, v;
        if (ch >= NumChan) return 1'b1;
        map_axis(dr, scale_r_reg, rows_in_use(), r0, r1, u);
        map_axis(dc, scale_c_reg, cols_in_use(), c0, c1, v);
        return written[ch][r0][c0] && written[ch][r0][c1]
            && written[ch][r1][c0] && written[ch][r1][c1];
    endfunction

    // idle the sender for a random while
    task automatic source_gap();
        while (!quiet_source && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // send one word and update the prediction on acceptance
    task automatic send_word(input t_stim s);
        source_gap();
        i_valid    <= 1'b1;
        i_command  <= s.cmd;
        i_channel  <= s.chan;
        i_row      <= s.row[8:0];
        i_col      <= s.col[8:0];
        i_pixel_in <= s.pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (s.cmd == CmdWrite) begin
            if (s.chan < NumChan && s.row < rows_in_use() && s.col < cols_in_use()) begin
                image_copy[s.chan][s.row][s.col] = s.pix;
                written[s.chan][s.row][s.col] = 1'b1;
            end
        end else begin
            pixels_due.push_back(s.has_fixed ? s.fixed : blend_pixel(s.chan, s.row, s.col));
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (Latency) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            RegSrcRows:   rows_reg    = val[7:0];
            RegSrcCols:   cols_reg    = val[8:0];
            RegScaleRows: scale_r_reg = val;
            default:      scale_c_reg = val;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input int r, input int c, input int sr, input int sc);
        write_reg(RegSrcRows, 16'(r));
        write_reg(RegSrcCols, 16'(c));
        write_reg(RegScaleRows, 16'(sr));
        write_reg(RegScaleCols, 16'(sc));
        i_cfg_valid <= 1'b0;
    endtask

    // fill every in-use pixel of every channel with random data
    task automatic fill_image();
        t_stim s;
        s = '{CmdWrite, 2'd0, 0, 0, 8'd0, 1'b0, 8'd0};
        for (int ch = 0; ch < NumChan; ch++)
            for (int r = 0; r < rows_in_use(); r++)
                for (int c = 0; c < cols_in_use(); c++) begin
                    s.chan = ch[1:0]; s.row = r; s.col = c;
                    s.pix = 8'($urandom);
                    send_word(s);
                end
    endtask

    // receive side: random stalls, in-order compare
    always @(negedge i_clk) begin
        i_ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pixels_due.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %0d", o_pixel_out));
            end else begin
                if (o_pixel_out !== pixels_due[0])
                    report_mismatch($sformatf("pixel_out got %0d want %0d",
                                              o_pixel_out, pixels_due[0]));
                void'(pixels_due.pop_front());
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallMax) begin
            $display("FAIL");
            $finish;
        end
    end

    // directed table on a tiny 2x3 image
    t_stim directed [] = '{
        '{CmdWrite, 2'd0, 0, 0, 8'd0,   1'b0, 8'd0},
        '{CmdWrite, 2'd0, 0, 1, 8'd255, 1'b0, 8'd0},
        '{CmdWrite, 2'd0, 0, 2, 8'd100, 1'b0, 8'd0},
        '{CmdWrite, 2'd0, 1, 0, 8'd255, 1'b0, 8'd0},
        '{CmdWrite, 2'd0, 1, 1, 8'd255, 1'b0, 8'd0},
        '{CmdWrite, 2'd0, 1, 2, 8'd7,   1'b0, 8'd0},
        '{CmdWrite, 2'd1, 0, 0, 8'd170, 1'b0, 8'd0},
        '{CmdWrite, 2'd1, 0, 1, 8'd85,  1'b0, 8'd0},
        '{CmdWrite, 2'd1, 0, 2, 8'd1,   1'b0, 8'd0},
        '{CmdWrite, 2'd1, 1, 0, 8'd2,   1'b0, 8'd0},
        '{CmdWrite, 2'd1, 1, 1, 8'd3,   1'b0, 8'd0},
        '{CmdWrite, 2'd1, 1, 2, 8'd4,   1'b0, 8'd0},
        '{CmdWrite, 2'd2, 0, 0, 8'd9,   1'b0, 8'd0},
        '{CmdWrite, 2'd2, 0, 1, 8'd9,   1'b0, 8'd0},
        '{CmdWrite, 2'd2, 0, 2, 8'd9,   1'b0, 8'd0},
        '{CmdWrite, 2'd2, 1, 0, 8'd9,   1'b0, 8'd0},
        '{CmdWrite, 2'd2, 1, 1, 8'd9,   1'b0, 8'd0},
        '{CmdWrite, 2'd2, 1, 2, 8'd9,   1'b0, 8'd0},
        // writes outside the size or channel are dropped
        '{CmdWrite, 2'd0, 511, 511, 8'd77, 1'b0, 8'd0},
        '{CmdWrite, 2'd3, 0, 0, 8'd77,     1'b0, 8'd0},
        '{CmdWrite, 2'd0, 0, 3, 8'd77,     1'b0, 8'd0},
        // bad channel reads zero; flat channel reads its value
        '{CmdRead, 2'd3, 0, 0, 8'd255,     1'b1, 8'd0},
        '{CmdRead, 2'd2, 511, 511, 8'd0,   1'b1, 8'd9},
        '{CmdRead, 2'd0, 0, 0, 8'd0,       1'b0, 8'd0},
        '{CmdRead, 2'd1, 1, 2, 8'd0,       1'b0, 8'd0}
    };

    initial begin
        t_stim s;
        int    k;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, identity scale on a 2x3 image
        set_geometry(2, 3, 4096, 4096);
        foreach (directed[i]) send_word(directed[i]);
        drain();

        // extremes: zero scale, zero sizes, maximum scale
        set_geometry(0, 0, 0, 65535);
        s = '{CmdWrite, 2'd0, 0, 0, 8'd200, 1'b0, 8'd0};
        send_word(s);
        s = '{CmdRead, 2'd0, 511, 511, 8'd0, 1'b1, 8'd200};
        send_word(s);
        drain();

        // random phases over several geometries
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_geometry(4, 5, 2048, 3000);
                1: set_geometry(3, 4, 65535, 0);
                2: set_geometry(255, 511, 1024, 40000);
                3: set_geometry(1, 2, 8192, 5000);
                4: set_geometry(2, 256, 4096, 1234);
                default: set_geometry(5, 3, $urandom_range(65535), $urandom_range(65535));
            endcase
            if (rows_in_use() * cols_in_use() <= 64) begin
                fill_image();
            end else begin
                // large frames: fill only the two-by-two corner blocks (top ones only in phase 2)
                s = '{CmdWrite, 2'd0, 0, 0, 8'd0, 1'b0, 8'd0};
                for (int ch = 0; ch < NumChan; ch++)
                    for (int r = 0; r < rows_in_use(); r++)
                        for (int c = 0; c < cols_in_use(); c++)
                            if ((r < 2 || r >= rows_in_use() - 2)
                                && (c < 2 || c >= cols_in_use() - 2)) begin
                                s.chan = ch[1:0]; s.row = r; s.col = c;
                                s.pix = 8'($urandom);
                                if (ph == 2) begin
                                    if (r < 2) send_word(s);
                                end else begin
                                    send_word(s);
                                end
                            end
            end
            quiet_sink = (ph == 1);
            quiet_source = (ph == 1);
            k = 0;
            while (k < 70) begin
                s.cmd  = ($urandom_range(99) < 70) ? CmdRead : CmdWrite;
                s.chan = 2'($urandom_range(3));
                s.row  = $urandom_range(511);
                s.col  = $urandom_range(511);
                if ($urandom_range(1)) s.row = $urandom_range(7);
                if ($urandom_range(1)) s.col = $urandom_range(7);
                s.pix  = 8'($urandom);
                s.has_fixed = 1'b0;
                if (s.cmd == CmdRead && !neighbours_known(s.chan, s.row, s.col))
                    continue;
                if (s.cmd == CmdWrite && ph == 2 && s.row >= 2)
                    continue;
                send_word(s);
                k++;
                // hold the sender until every pixel has come back
                if (k == 35) begin
                    i_valid <= 1'b0;
                    @(negedge i_clk);
                    while (pixels_due.size() != 0) @(negedge i_clk);
                end
            end
            quiet_sink = 1'b0;
            quiet_source = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bir_pkg.sv
hw/rtl/bir_ram.sv
hw/rtl/bir_coord_map.sv
hw/rtl/bir_blend.sv
hw/rtl/bilinear_image_resize.sv
dv/tb_bilinear_image_resize.sv
